// ----- src/esd_pkg.sv -----
// ----------------------------------------------------------------------------
// esd_pkg: shared types, character codes and helpers for the escape decoder
// Holds the decode mode enum, the result beat struct and the small
// character classification functions used by the decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

    localparam int CHAR_W = 16;
    localparam int HEX_W  = 8;

    // decode mode: normal, just after a backslash, collecting hex digits
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_X         = 16'h0078;
    localparam logic [CHAR_W-1:0] CH_A         = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_B         = 16'h0062;
    localparam logic [CHAR_W-1:0] CH_F         = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_N         = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_R         = 16'h0072;
    localparam logic [CHAR_W-1:0] CH_T         = 16'h0074;
    localparam logic [CHAR_W-1:0] CH_V         = 16'h0076;
    localparam logic [CHAR_W-1:0] CH_0         = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_9         = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_UA        = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UF        = 16'h0046;

    // control codes produced by the mapped escapes
    localparam logic [CHAR_W-1:0] CODE_BEL = 16'd7;
    localparam logic [CHAR_W-1:0] CODE_BS  = 16'd8;
    localparam logic [CHAR_W-1:0] CODE_HT  = 16'd9;
    localparam logic [CHAR_W-1:0] CODE_LF  = 16'd10;
    localparam logic [CHAR_W-1:0] CODE_VT  = 16'd11;
    localparam logic [CHAR_W-1:0] CODE_FF  = 16'd12;
    localparam logic [CHAR_W-1:0] CODE_CR  = 16'd13;

    // most hex digits taken after \x
    localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;

    // one result beat
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              end_of_text;
    } res_t;

    // hex digit check: bit 4 = is a digit, bits 3:0 = its value
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = '0;
            if (c >= CH_0 && c <= CH_9)
            begin
                d = c - CH_0;
                hex_digit = {1'b1, d[3:0]};
            end
            else if (c >= CH_A && c <= CH_F)
            begin
                d = c - CH_A + 16'd10;
                hex_digit = {1'b1, d[3:0]};
            end
            else if (c >= CH_UA && c <= CH_UF)
            begin
                d = c - CH_UA + 16'd10;
                hex_digit = {1'b1, d[3:0]};
            end
            else
            begin
                hex_digit = 5'd0;
            end
        end
    endfunction

    // single-letter escapes; anything else stands for itself
    function automatic logic [CHAR_W-1:0] map_escape(input logic [CHAR_W-1:0] c);
        begin
            unique case (c)
                CH_A:    map_escape = CODE_BEL;
                CH_B:    map_escape = CODE_BS;
                CH_F:    map_escape = CODE_FF;
                CH_N:    map_escape = CODE_LF;
                CH_R:    map_escape = CODE_CR;
                CH_T:    map_escape = CODE_HT;
                CH_V:    map_escape = CODE_VT;
                default: map_escape = c;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/escape_sequence_decoder_top.sv -----
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top: C-style backslash escape decoder
// Decodes one 16-bit character per input beat and emits up to two result
// beats through a two-entry result buffer.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   input   | in_valid / in_ready | char_code, last_in_text
//   output  | out_valid/out_ready | out_char, char_valid, end_of_text
//
// A character is decoded in the cycle it is taken; its results appear on the
// output from the next cycle. One character per cycle while the sink keeps
// up; a character that flushes a pending hex value gives two beats and so
// holds the input while both are pending. The input is taken only when the
// result buffer will be empty after this cycle's output beat. Reset clears
// the decode state and empties the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] char_code,
    input  wire logic        last_in_text,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_char,
    output logic             char_valid,
    output logic             end_of_text
);

    // decode state
    esd_pkg::mode_t            mode_reg, mode_next;
    logic [esd_pkg::HEX_W-1:0] acc_reg, acc_next;
    logic [1:0]                hcnt_reg, hcnt_next;

    // result buffer, entry 0 is the head
    esd_pkg::res_t             buf0_reg, buf1_reg;
    logic [1:0]                count_reg;

    esd_pkg::res_t             res0, res1;
    logic [1:0]                nres;

    logic                      accept;
    logic                      pop;
    logic [4:0]                hd;
    logic                      take_digit;
    logic                      flush;
    logic                      is_esc;
    logic [esd_pkg::HEX_W-1:0] acc_shift;

    // handshake
    assign pop      = out_valid && out_ready;
    assign in_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign accept   = in_valid && in_ready;

    // character classification
    assign hd         = esd_pkg::hex_digit(char_code);
    assign take_digit = (mode_reg == esd_pkg::MODE_HEX) &&
                        (hcnt_reg < esd_pkg::HEX_MAX_DIGITS) && hd[4];
    assign flush      = (mode_reg == esd_pkg::MODE_HEX) && !take_digit;
    assign is_esc     = (mode_reg == esd_pkg::MODE_ESC);
    assign acc_shift  = {acc_reg[3:0], hd[3:0]};

    // next decode state
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        hcnt_next = hcnt_reg;
        if (take_digit)
        begin
            acc_next  = acc_shift;
            hcnt_next = hcnt_reg + 2'd1;
        end
        else if (is_esc && char_code == esd_pkg::CH_X)
        begin
            mode_next = esd_pkg::MODE_HEX;
            acc_next  = '0;
            hcnt_next = '0;
        end
        else if (!is_esc && char_code == esd_pkg::CH_BACKSLASH)
        begin
            // normal mode, or normal after a hex flush
            mode_next = esd_pkg::MODE_ESC;
            acc_next  = '0;
            hcnt_next = '0;
        end
        else
        begin
            mode_next = esd_pkg::MODE_NORMAL;
            acc_next  = '0;
            hcnt_next = '0;
        end
        // end of text returns everything to reset values
        if (last_in_text)
        begin
            mode_next = esd_pkg::MODE_NORMAL;
            acc_next  = '0;
            hcnt_next = '0;
        end
    end

    // result beats for this character
    always_comb
    begin
        res0 = '0;
        res1 = '0;
        nres = 2'd0;
        if (take_digit)
        begin
            if (last_in_text)
            begin
                res0 = '{out_char: {8'd0, acc_shift}, char_valid: 1'b1,
                         end_of_text: 1'b1};
                nres = 2'd1;
            end
        end
        else if (is_esc)
        begin
            if (char_code == esd_pkg::CH_X)
            begin
                if (last_in_text)
                begin
                    res0 = '{out_char: '0, char_valid: 1'b1, end_of_text: 1'b1};
                    nres = 2'd1;
                end
            end
            else
            begin
                res0 = '{out_char: esd_pkg::map_escape(char_code), char_valid: 1'b1,
                         end_of_text: last_in_text};
                nres = 2'd1;
            end
        end
        else
        begin
            // normal handling, preceded by the pending hex value on a flush
            if (char_code == esd_pkg::CH_BACKSLASH)
            begin
                res1 = '{out_char: '0, char_valid: 1'b0, end_of_text: 1'b1};
            end
            else
            begin
                res1 = '{out_char: char_code, char_valid: 1'b1,
                         end_of_text: last_in_text};
            end
            if (flush)
            begin
                res0 = '{out_char: {8'd0, acc_reg}, char_valid: 1'b1,
                         end_of_text: 1'b0};
                nres = (char_code == esd_pkg::CH_BACKSLASH && !last_in_text) ?
                       2'd1 : 2'd2;
            end
            else
            begin
                res0 = res1;
                nres = (char_code == esd_pkg::CH_BACKSLASH && !last_in_text) ?
                       2'd0 : 2'd1;
            end
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_NORMAL;
            acc_reg  <= '0;
            hcnt_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            hcnt_reg <= hcnt_next;
        end
    end

    // result buffer count; an accept only happens when it drains to empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= nres;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf0_reg <= res0;
            buf1_reg <= res1;
        end
        else if (pop)
        begin
            buf0_reg <= buf1_reg;
        end
    end

    assign out_valid   = (count_reg != 2'd0);
    assign out_char    = buf0_reg.out_char;
    assign char_valid  = buf0_reg.char_valid;
    assign end_of_text = buf0_reg.end_of_text;

    // checks
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer overfilled");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !in_ready)
        else $error("input taken with two beats still pending");

    a_flush_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !buf0_reg.end_of_text)
        else $error("flushed hex beat marked end");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_in_text) |=>
            (mode_reg == esd_pkg::MODE_NORMAL && acc_reg == '0 && hcnt_reg == '0))
        else $error("state not cleared after end of text");

    a_cnt_hex_only: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != esd_pkg::MODE_HEX) |-> (hcnt_reg == 2'd0))
        else $error("digit count set outside hex mode");

endmodule

`default_nettype wire
